// File: hdl/slbe_pkg.sv
package slbe_pkg;

  // default parameter values
  localparam int COUNT_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 12;

  // fixed field and accumulator widths
  localparam int SUM_W    = 44;
  localparam int SQ_W     = 64;
  localparam int MEAN_W   = 20;
  localparam int STAT_W   = 24;
  localparam int TOTAL_W  = 24;
  localparam int PIX_W    = 8;
  localparam int STAT_FRAC = 12;

  // shared divider
  localparam int DIV_W  = 64;
  localparam int STEP_W = 7;

  // upper pixel must stay below this
  localparam logic [PIX_W-1:0] SAT_LIMIT = 8'd250;

  // config register addresses
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_DARK_THR = 3'd0;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_PAIR   = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAIR_DIV,
    S_PAIR_MUL,
    S_PAIR_ACC,
    S_MEAN_DIV,
    S_MSQ_DIV,
    S_MSQ_MUL,
    S_VAR_CHK,
    S_SQRT,
    S_ROOT_CHK,
    S_STAT_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hdl/slbe_div.sv
module slbe_div #(
  parameter int DVW = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slbe_pkg::div_req_t  req,
  input  logic [DVW-1:0]      divisor,
  output slbe_pkg::div_rsp_t  rsp
);
  import slbe_pkg::*;

  logic [DIV_W-1:0]  acc_r;
  logic [DVW-1:0]    rem_r;
  logic [DVW-1:0]    dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              done_r;

  logic [DVW:0] rem_sh;
  logic [DVW:0] diff;
  logic         ge;

  // one restoring step: bring down the next dividend bit
  assign rem_sh = {rem_r, acc_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == STEP_W'(1));
      if (req.start) begin
        cnt_r <= req.steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - STEP_W'(1);
      end
    end
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      acc_r <= {acc_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = acc_r;

endmodule

// File: hdl/scan_line_bias_estimator_unit.sv
// scan line bias estimator
// input beats carry a pixel pair (tdata) and an op code (tuser): clear,
// pair or report. a pair is tested against the dark threshold, the
// saturation limit, a zero lower pixel and a full pair count; a
// qualifying pair runs the shared radix-2 divider for its ratio
// (8+FRACTION_BITS steps), then the multiplier and the accumulators. the
// divider gives one quotient bit per cycle. a pair that does not qualify
// goes back to idle without the divider.
// a report runs the divider for the mean (44 steps) and the mean square
// (64 steps), a multiply, a bit-serial square root (8+FRACTION_BITS steps)
// and a last divide (20+FRACTION_BITS steps); these last two are skipped
// for a zero variance or root; a report with no pairs skips to the output.
// in_tready is high only while the sequencer is idle, one item at a time.
// the result sits in an output register; the next input beat is taken
// while it waits, and a following report holds in its last state until
// out_tready frees the register.
// reset clears the accumulators, the threshold and out_tvalid.
// dark_threshold is written through the apb port at address 0.
module scan_line_bias_estimator_unit #(
  parameter int COUNT_BITS    = slbe_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = slbe_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // upper_pixel[7:0], lower_pixel[15:8]
  input  logic [1:0]  in_tuser,   // op[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // bias_mean[19:0], bias_stat[43:20],
                                  // pair_total[67:44], zero pad[71:68]
  output logic [0:0]  out_tuser,  // degenerate[0]
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [slbe_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import slbe_pkg::*;

  localparam int RW      = PIX_W + FRACTION_BITS;
  localparam int DVW     = (COUNT_BITS > RW) ? COUNT_BITS : RW;
  localparam int SQC_W   = $clog2(RW + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [RW-1:0] ONE = RW'(1) << FRACTION_BITS;

  state_t state_r, state_nxt;

  logic [PIX_W-1:0]      thr_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SQ_W-1:0]       sq_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [RW-1:0]         ratio_r;
  logic [RW-1:0]         mean_r;
  logic [2*RW-1:0]       meansq_r;
  logic [2*RW-1:0]       prod_r;
  logic [2*RW-1:0]       var_r;
  logic [RW+2:0]         srem_r;
  logic [RW-1:0]         root_r;
  logic [SQC_W-1:0]      sq_cnt_r;
  logic [STAT_W-1:0]     stat_r;
  logic                  degen_r;

  logic                  out_valid_r;
  logic [MEAN_W-1:0]     out_mean_r;
  logic [STAT_W-1:0]     out_stat_r;
  logic [TOTAL_W-1:0]    out_total_r;
  logic                  out_degen_r;

  div_req_t       div_req;
  div_rsp_t       div_rsp;
  logic [DVW-1:0] div_divisor;

  op_t              op;
  logic [PIX_W-1:0] up_pix;
  logic [PIX_W-1:0] lo_pix;
  logic             in_acc;
  logic             qualify;
  logic             out_free;

  logic [RW-1:0]   dev;
  logic [RW-1:0]   mul_a;
  logic [SUM_W:0]  sum_add;
  logic [SQ_W:0]   sq_add;
  logic [RW+2:0]   srem_sh;
  logic [RW+2:0]   strial;
  logic            sge;

  assign op      = op_t'(in_tuser);
  assign up_pix  = in_tdata[PIX_W-1:0];
  assign lo_pix  = in_tdata[2*PIX_W-1:PIX_W];
  assign in_acc  = in_tvalid && in_tready;
  assign qualify = (up_pix > thr_r) && (up_pix < SAT_LIMIT) &&
                   (lo_pix != '0) && (count_r != COUNT_MAX);
  assign out_free = !out_valid_r || out_tready;

  assign dev = (mean_r >= ONE) ? (mean_r - ONE) : (ONE - mean_r);

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_DARK_THR) ? {24'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_DARK_THR) begin
      thr_r <= cfg_pwdata[PIX_W-1:0];
    end
  end

  // shared divider
  slbe_div #(.DVW(DVW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (div_divisor),
    .rsp     (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_PAIR:   state_nxt = qualify ? S_PAIR_DIV : S_IDLE;
            OP_REPORT: state_nxt = (count_r == '0) ? S_OUT : S_MEAN_DIV;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_PAIR_DIV: if (div_rsp.done) state_nxt = S_PAIR_MUL;
      S_PAIR_MUL: state_nxt = S_PAIR_ACC;
      S_PAIR_ACC: state_nxt = S_IDLE;
      S_MEAN_DIV: if (div_rsp.done) state_nxt = S_MSQ_DIV;
      S_MSQ_DIV:  if (div_rsp.done) state_nxt = S_MSQ_MUL;
      S_MSQ_MUL:  state_nxt = S_VAR_CHK;
      S_VAR_CHK:  state_nxt = (meansq_r <= prod_r) ? S_OUT : S_SQRT;
      S_SQRT:     if (sq_cnt_r == SQC_W'(1)) state_nxt = S_ROOT_CHK;
      S_ROOT_CHK: state_nxt = (root_r == '0) ? S_OUT : S_STAT_DIV;
      S_STAT_DIV: if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and divider launch
  always_comb begin
    in_tready        = (state_r == S_IDLE);
    div_req.start    = (state_nxt != state_r) &&
                       (state_nxt == S_PAIR_DIV || state_nxt == S_MEAN_DIV ||
                        state_nxt == S_MSQ_DIV  || state_nxt == S_STAT_DIV);
    div_req.steps    = STEP_W'(RW);
    div_req.dividend = DIV_W'(up_pix) << (DIV_W - PIX_W);
    div_divisor      = DVW'(lo_pix);
    case (state_nxt)
      S_MEAN_DIV: begin
        div_req.steps    = STEP_W'(SUM_W);
        div_req.dividend = DIV_W'(sum_r) << (DIV_W - SUM_W);
        div_divisor      = DVW'(count_r);
      end
      S_MSQ_DIV: begin
        div_req.steps    = STEP_W'(SQ_W);
        div_req.dividend = DIV_W'(sq_r) << (DIV_W - SQ_W);
        div_divisor      = DVW'(count_r);
      end
      S_STAT_DIV: begin
        div_req.steps    = STEP_W'(RW + STAT_FRAC);
        div_req.dividend = DIV_W'(dev) << (DIV_W - RW);
        div_divisor      = DVW'(root_r);
      end
      default: begin
        div_req.steps    = STEP_W'(RW);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // shared multiplier, registered
  assign mul_a = (state_r == S_MSQ_MUL) ? mean_r : ratio_r;

  always_ff @(posedge clk) begin
    if (state_r == S_PAIR_MUL || state_r == S_MSQ_MUL) begin
      prod_r <= mul_a * mul_a;
    end
  end

  // saturating accumulation
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(ratio_r);
  assign sq_add  = {1'b0, sq_r} + (SQ_W+1)'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      sq_r    <= '0;
      count_r <= '0;
    end else if (in_acc && op == OP_CLEAR) begin
      sum_r   <= '0;
      sq_r    <= '0;
      count_r <= '0;
    end else if (state_r == S_PAIR_ACC) begin
      sum_r   <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      sq_r    <= sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
      count_r <= count_r + COUNT_BITS'(1);
    end
  end

  // one square root step: bring down two bits of the variance
  assign srem_sh = {srem_r[RW:0], var_r[2*RW-1:2*RW-2]};
  assign strial  = (RW+3)'({root_r, 2'b01});
  assign sge     = srem_sh >= strial;

  // report datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        mean_r  <= '0;
        stat_r  <= '0;
        degen_r <= 1'b1;
      end
      S_PAIR_DIV: if (div_rsp.done) ratio_r <= div_rsp.quotient[RW-1:0];
      S_MEAN_DIV: if (div_rsp.done) mean_r <= div_rsp.quotient[RW-1:0];
      S_MSQ_DIV:  if (div_rsp.done) meansq_r <= div_rsp.quotient[2*RW-1:0];
      S_VAR_CHK: begin
        degen_r  <= 1'b1;
        stat_r   <= (dev != '0) ? {STAT_W{1'b1}} : '0;
        var_r    <= meansq_r - prod_r;
        srem_r   <= '0;
        root_r   <= '0;
        sq_cnt_r <= SQC_W'(RW);
      end
      S_SQRT: begin
        srem_r   <= sge ? (srem_sh - strial) : srem_sh;
        root_r   <= {root_r[RW-2:0], sge};
        var_r    <= {var_r[2*RW-3:0], 2'b00};
        sq_cnt_r <= sq_cnt_r - SQC_W'(1);
      end
      S_STAT_DIV: begin
        if (div_rsp.done) begin
          degen_r <= 1'b0;
          stat_r  <= (div_rsp.quotient[DIV_W-1:STAT_W] != '0) ?
                     {STAT_W{1'b1}} : div_rsp.quotient[STAT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_mean_r  <= (mean_r > RW'({MEAN_W{1'b1}})) ? {MEAN_W{1'b1}} :
                     MEAN_W'(mean_r);
      out_stat_r  <= stat_r;
      out_total_r <= TOTAL_W'(count_r);
      out_degen_r <= degen_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_total_r, out_stat_r, out_mean_r};
  assign out_tuser  = out_degen_r;

endmodule

// File: hdl/slbe_checker.sv
module slbe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [1:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [71:0]                 out_tdata,
  input logic [0:0]                  out_tuser
);
  import slbe_pkg::*;

  // a held result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // in_tready drops right after a report beat is taken
  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_REPORT |=> !in_tready)
    else $error("ready right after a report beat");

  // an empty report reads all zero and is flagged degenerate
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67:44] == 24'd0 |->
      out_tuser[0] && out_tdata[43:0] == 44'd0)
    else $error("empty report not zero and degenerate");

  // no result comes out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind scan_line_bias_estimator_unit slbe_checker u_slbe_checker (.*);

// File: verif/scan_line_bias_estimator_unit_tb.sv
module scan_line_bias_estimator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slbe_pkg::*;

  localparam int FB        = FRACTION_BITS_DEF;
  localparam int CB        = COUNT_BITS_DEF;
  localparam int WATCHDOG  = 20000;
  localparam int RX_HOLD   = 1500;

  typedef struct packed {
    op_t        op;
    logic [7:0] upper;
    logic [7:0] lower;
  } pixel_beat_t;

  typedef struct packed {
    logic [19:0] mean;
    logic [23:0] stat;
    logic [23:0] total;
    logic        degen;
  } bias_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  scan_line_bias_estimator_unit dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [7:0]  thr_model;
  logic [43:0] sum_model;
  logic [63:0] sq_model;
  logic [23:0] cnt_model;

  pixel_beat_t  pending_beats[$];
  bias_report_t expected_reports[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;          // no idling in the last part
  bit rx_hold_start = 1'b0; // asks the receiver for one long hold-off
  bit rx_hold_done = 1'b0;
  int rx_hold_left = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // update accumulators, produce a report when asked
  function automatic bit predict_bias(pixel_beat_t b, output bias_report_t r);
    logic [63:0] ratio, square, mean, meansq, msq, dev, sd, stat;
    logic [63:0] one;
    one = 64'd1 << FB;
    r = '0;
    case (b.op)
      OP_CLEAR: begin
        sum_model = 0; sq_model = 0; cnt_model = 0;
        return 0;
      end
      OP_PAIR: begin
        if (b.upper > thr_model && b.upper < SAT_LIMIT && b.lower != 0 &&
            cnt_model != {CB{1'b1}}) begin
          ratio = (64'(b.upper) << FB) / 64'(b.lower);
          square = ratio * ratio;
          cnt_model++;
          sum_model = (ratio > 64'(44'hFFF_FFFF_FFFF - sum_model)) ?
                      44'hFFF_FFFF_FFFF : sum_model + 44'(ratio);
          sq_model = (square > ~sq_model) ? '1 : sq_model + square;
        end
        return 0;
      end
      OP_REPORT: begin
        if (cnt_model == 0) begin
          r.degen = 1'b1;
          return 1;
        end
        mean = 64'(sum_model) / 64'(cnt_model);
        meansq = sq_model / 64'(cnt_model);
        msq = mean * mean;
        dev = (mean >= one) ? mean - one : one - mean;
        stat = 0;
        sd = (meansq > msq) ? isqrt(meansq - msq) : 0;
        if (sd == 0) begin
          r.degen = 1'b1;
          stat = (dev != 0) ? 64'hFF_FFFF : 0;
        end else begin
          stat = (dev << STAT_FRAC) / sd;
          if (stat > 64'hFF_FFFF) stat = 64'hFF_FFFF;
        end
        r.mean = (mean > 64'hF_FFFF) ? 20'hF_FFFF : mean[19:0];
        r.stat = stat[23:0];
        r.total = cnt_model;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // input driver
  int tx_gap = 0;
  always @(posedge clk) begin
    bias_report_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (predict_bias(pending_beats[0], r)) expected_reports.push_back(r);
        void'(pending_beats.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold current beat
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        tx_gap <= $urandom_range(0, 6);
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_beats[0].op;
        in_tdata <= {pending_beats[0].lower, pending_beats[0].upper};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  int rx_gap = 0;
  always @(posedge clk) begin
    bias_report_t got, exp_r;
    if (rst_n) begin
      if (in_tvalid && in_tready || out_tvalid && out_tready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got = {out_tdata[19:0], out_tdata[43:20], out_tdata[67:44], out_tuser[0]};
        if (expected_reports.size() == 0) begin
          $error("report beat with nothing expected");
          errors++;
        end else begin
          exp_r = expected_reports.pop_front();
          if (got.mean !== exp_r.mean) begin
            $error("bias_mean exp %0d got %0d", exp_r.mean, got.mean); errors++;
          end
          if (got.stat !== exp_r.stat) begin
            $error("bias_stat exp %0d got %0d", exp_r.stat, got.stat); errors++;
          end
          if (got.total !== exp_r.total) begin
            $error("pair_total exp %0d got %0d", exp_r.total, got.total); errors++;
          end
          if (got.degen !== exp_r.degen) begin
            $error("degenerate exp %0d got %0d", exp_r.degen, got.degen); errors++;
          end
        end
      end
      if (rx_hold_start && !rx_hold_done) begin
        rx_hold_done <= 1'b1;
        rx_hold_left <= RX_HOLD - 1;
        out_tready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic cfg_write(logic [7:0] thr);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= REG_DARK_THR;
    cfg_pwdata <= {24'h0, thr};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    thr_model = thr;
  endtask

  task automatic push_beat(op_t op, logic [7:0] up, logic [7:0] lo);
    pixel_beat_t b;
    b.op = op; b.upper = up; b.lower = lo;
    pending_beats.push_back(b);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // random image: mostly qualifying pairs around a bias
  task automatic push_image(int n);
    int bias;
    logic [7:0] lo;
    bias = $urandom_range(0, 20);
    push_beat(OP_CLEAR, 8'($urandom), 8'($urandom));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: push_beat(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        1: push_beat(OP_PAIR, 8'($urandom), 8'($urandom));
        2: push_beat(OP_REPORT, 8'($urandom), 8'($urandom));
        default: begin
          lo = 8'($urandom_range(1, 230));
          push_beat(OP_PAIR, 8'(lo + $urandom_range(0, bias)), lo);
        end
      endcase
    end
    push_beat(OP_REPORT, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    thr_model = 0; sum_model = 0; sq_model = 0; cnt_model = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty report, extremes, degenerate, unused op
    push_beat(OP_REPORT, 8'hFF, 8'hFF);
    push_beat(OP_PAIR, 8'd100, 8'd100);
    push_beat(OP_REPORT, 8'd0, 8'd0);
    push_beat(OP_PAIR, 8'd249, 8'd1);
    push_beat(OP_PAIR, 8'd250, 8'd1);
    push_beat(OP_PAIR, 8'd255, 8'd255);
    push_beat(OP_PAIR, 8'd10, 8'd0);
    push_beat(OP_PAIR, 8'd0, 8'd5);
    push_beat(OP_PAIR, 8'd1, 8'd255);
    push_beat(OP_NONE, 8'hAA, 8'h55);
    push_beat(OP_REPORT, 8'h55, 8'hAA);
    push_beat(OP_CLEAR, 8'd0, 8'd0);
    push_beat(OP_PAIR, 8'd60, 8'd30);
    push_beat(OP_PAIR, 8'd60, 8'd30);
    push_beat(OP_REPORT, 8'd0, 8'd0);
    push_beat(OP_PAIR, 8'd128, 8'd128);
    push_beat(OP_REPORT, 8'd0, 8'd0);
    wait_drained();

    // threshold extremes
    cfg_write(8'd255);
    push_beat(OP_PAIR, 8'd200, 8'd100);
    push_beat(OP_REPORT, 8'd0, 8'd0);
    wait_drained();
    cfg_write(8'd128);
    push_beat(OP_PAIR, 8'd128, 8'd3);
    push_beat(OP_PAIR, 8'd129, 8'd3);
    push_beat(OP_REPORT, 8'd0, 8'd0);

    // receiver holds off while sender keeps offering
    rx_hold_start = 1'b1;
    push_image(20);
    wait (rx_hold_done && rx_hold_left == 0);
    wait_drained();

    // random phases over thresholds
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(ph == 0 ? 8'd0 : 8'($urandom_range(0, 120)));
      for (int k = 0; k < 4; k++) push_image($urandom_range(5, 25));
      if (ph == 4) calm = 1'b1;
      wait_drained();
    end
    cfg_write(8'd0);
    push_image(100);
    wait_drained();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
